/* sv/sawc_pkg.sv */
package sawc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_WBACK,
    ST_FILL,
    ST_ACCESS,
    ST_DONE
  } state_t;

  localparam logic [15:0] LfsrSeed = 16'hACE1;
  localparam logic [15:0] LfsrMask = 16'hB400;
  localparam int unsigned AddrW = 20;
  localparam int unsigned DataW = 64;
  localparam int unsigned CountW = 32;

  function automatic logic [15:0] lfsr_step(input logic [15:0] s);
    logic [15:0] r;
    r = {1'b0, s[15:1]};
    if (s[0]) begin
      r = r ^ LfsrMask;
    end
    return r;
  endfunction

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    return (v == '1) ? v : v + CountW'(1);
  endfunction

endpackage

/* sv/sawc_mem.sv */
// simple dual-port word memory: byte-enabled write port, registered read port
module sawc_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW = 10
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [sawc_pkg::DataW-1:0]  wdata,
  input  logic [7:0]                  wbe,
  input  logic [AW-1:0]               raddr,
  output logic [sawc_pkg::DataW-1:0]  rdata
);
  logic [sawc_pkg::DataW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int b = 0; b < 8; b++) begin
        if (wbe[b]) begin
          mem[waddr][b*8 +: 8] <= wdata[b*8 +: 8];
        end
      end
    end
    rdata <= mem[raddr];
  end
endmodule

/* sv/set_assoc_writeback_cache.sv */
// flow: a request is looked up way by way; a hit goes on to the access, a miss first fills
// the line from backing memory, writing back a dirty victim before that when the set is full
// and no way is invalid; a rejected access goes straight from the lookup to the answer
// throughput: one request at a time; the next is taken only after the answer is accepted
// reset: synchronous; then a clearing pass zeroes the backing memory and the line tags,
// one word a cycle, before the first request is taken
module set_assoc_writeback_cache #(
  parameter int unsigned SETS = 128,
  parameter int unsigned WAYS = 4,
  parameter int unsigned LINE_BYTES = 64,
  parameter int unsigned MEM_BYTES = 1048576
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [19:0] addr,
  input  logic [63:0] wdata,
  input  logic [3:0]  size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] rdata,
  output logic        hit,
  output logic        wrote_back,
  output logic        error,
  output logic [31:0] hit_count,
  output logic [31:0] miss_count
);
  localparam int unsigned OB = $clog2(LINE_BYTES);
  localparam int unsigned IB = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned IBR = $clog2(SETS);
  localparam int unsigned WB = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned WPL = LINE_BYTES / 8;
  localparam int unsigned WOB = (WPL > 1) ? $clog2(WPL) : 1;
  localparam int unsigned TW = (20 > OB + IBR) ? 20 - OB - IBR : 1;
  localparam int unsigned NL = SETS * WAYS;
  localparam int unsigned LB = $clog2(NL) > 0 ? $clog2(NL) : 1;
  localparam int unsigned MW = MEM_BYTES / 8;
  localparam int unsigned MB = $clog2(MW);
  localparam int unsigned CDW = NL * WPL;
  localparam int unsigned CDB = $clog2(CDW);
  localparam int unsigned CLR_N = (NL > MW) ? NL : MW;
  localparam int unsigned CLRB = $clog2(CLR_N);

  sawc_pkg::state_t state, state_next;

  // request registers
  logic        r_func;
  logic [19:0] r_addr;
  logic [63:0] r_wdata;
  logic [3:0]  r_size;

  logic [15:0] lfsr;
  logic [31:0] hcnt, mcnt;
  logic [WB-1:0] way;
  logic [WB:0]   wscan;
  logic          found;
  logic [WB-1:0] inv_way;
  logic          inv_found;
  logic          vic_dirty;
  logic [TW-1:0] vic_tag;
  logic [WOB:0]  wcnt;
  logic [CLRB:0] clr;
  logic          clearing;

  logic [IB-1:0] set_i;
  logic [TW-1:0] tag_i;
  logic [OB-1:0] off_i;
  logic [LB-1:0] line_i;

  always_comb begin
    set_i = '0;
    if (IBR > 0) set_i = IB'(r_addr >> OB);
    tag_i = TW'(r_addr >> (OB + IBR));
    off_i = OB'(r_addr);
    line_i = LB'(NL > 1 ? (32'(set_i) % SETS) * WAYS + 32'(way) : 0);
  end

  logic [LB-1:0] scan_line;
  assign scan_line = LB'(NL > 1 ? (32'(set_i) % SETS) * WAYS + 32'(wscan[WB-1:0]) : 0);

  // per-line valid, dirty and tag; registered read, one write a cycle
  logic [TW+1:0] meta [NL];
  logic [TW+1:0] meta_q;
  logic          meta_we;
  logic [LB-1:0] meta_waddr;
  logic [TW+1:0] meta_wdata;
  logic          m_valid, m_dirty;
  logic [TW-1:0] m_tag;

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta[meta_waddr] <= meta_wdata;
    end
    meta_q <= meta[scan_line];
  end

  assign m_valid = meta_q[TW+1];
  assign m_dirty = meta_q[TW];
  assign m_tag = meta_q[TW-1:0];

  // the tag word in meta_q belongs to the way scanned in the previous cycle
  logic [WB-1:0] prev_way;
  assign prev_way = WB'(wscan - (WB+1)'(1));
  // victim way if the set turns out full
  logic [WB-1:0] lfsr_pick;
  assign lfsr_pick = WB'(32'(sawc_pkg::lfsr_step(lfsr)) % WAYS);

  // cache data memory
  logic          cd_we;
  logic [CDB-1:0] cd_waddr, cd_raddr;
  logic [63:0]   cd_wdata, cd_rdata;
  logic [7:0]    cd_be;
  sawc_mem #(.DEPTH(CDW), .AW(CDB)) u_cdata (
    .clk(clk), .we(cd_we), .waddr(cd_waddr), .wdata(cd_wdata), .wbe(cd_be),
    .raddr(cd_raddr), .rdata(cd_rdata)
  );

  // backing memory
  logic          bm_we;
  logic [MB-1:0] bm_waddr, bm_raddr;
  logic [63:0]   bm_wdata, bm_rdata;
  sawc_mem #(.DEPTH(MW), .AW(MB)) u_bmem (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata), .wbe(8'hFF),
    .raddr(bm_raddr), .rdata(bm_rdata)
  );

  // word indexes within line; wcnt counts issued reads, data comes back in the next cycle (widx_d)
  logic [WOB-1:0] widx, widx_d;
  assign widx = WOB'(wcnt);
  assign widx_d = WOB'(wcnt - (WOB+1)'(1));
  logic [MB-1:0] new_base, victim_base;
  assign new_base = MB'({r_addr[19:OB], {OB{1'b0}}} >> 3);
  assign victim_base = MB'(((32'(vic_tag) << (OB + IBR)) | (32'(set_i) << OB)) >> 3);

  // byte access: word within line and byte lanes
  logic [WOB-1:0] aw;
  logic [2:0]     ab;
  assign aw = WOB'(off_i >> 3);
  assign ab = off_i[2:0];
  logic [3:0] ssz;
  logic       bad;
  assign bad = (r_size == 4'd0) || (r_size > 4'd8) ||
               (32'(off_i) + 32'(r_size) > LINE_BYTES);
  logic [127:0] pair;
  logic [63:0]  lo_word;
  logic [WOB:0] acnt;
  assign ssz = r_size;

  // read data spans up to two words; collect them
  logic [15:0] bmask;
  assign bmask = 16'((16'h1 << ssz) - 16'h1) << ab;

  logic wrb;

  always_comb begin
    state_next = state;
    unique case (state)
      sawc_pkg::ST_IDLE:   if (in_valid && !clearing) state_next = sawc_pkg::ST_LOOKUP;
      sawc_pkg::ST_LOOKUP: begin
        if (bad) state_next = sawc_pkg::ST_DONE;
        else if (found) state_next = sawc_pkg::ST_ACCESS;
        else if (32'(wscan) > WAYS) begin
          // a full set evicts the lfsr way; write it back if dirty
          if (!inv_found && vic_dirty) state_next = sawc_pkg::ST_WBACK;
          else state_next = sawc_pkg::ST_FILL;
        end
      end
      sawc_pkg::ST_WBACK:  if (32'(wcnt) == WPL) state_next = sawc_pkg::ST_FILL;
      sawc_pkg::ST_FILL:   if (32'(wcnt) == WPL) state_next = sawc_pkg::ST_ACCESS;
      sawc_pkg::ST_ACCESS: if (acnt == (WOB+1)'(3)) state_next = sawc_pkg::ST_DONE;
      sawc_pkg::ST_DONE:   if (out_ready) state_next = sawc_pkg::ST_IDLE;
      default: state_next = sawc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == sawc_pkg::ST_IDLE) && !clearing;
    out_valid = (state == sawc_pkg::ST_DONE);
    cd_we = 1'b0; cd_waddr = '0; cd_wdata = '0; cd_be = 8'h00; cd_raddr = '0;
    bm_we = 1'b0; bm_waddr = '0; bm_wdata = '0; bm_raddr = '0;
    meta_we = 1'b0; meta_waddr = '0; meta_wdata = '0;
    unique case (state)
      sawc_pkg::ST_WBACK: begin
        cd_raddr = CDB'(32'(line_i) * WPL + 32'(widx));
        bm_we = (wcnt != '0);
        bm_waddr = MB'(victim_base + MB'(widx_d));
        bm_wdata = cd_rdata;
      end
      sawc_pkg::ST_FILL: begin
        bm_raddr = MB'(new_base + MB'(widx));
        cd_we = (wcnt != '0);
        cd_be = 8'hFF;
        cd_waddr = CDB'(32'(line_i) * WPL + 32'(widx_d));
        cd_wdata = bm_rdata;
        // last word in: line becomes valid and clean under the new tag
        if (32'(wcnt) == WPL) begin
          meta_we = 1'b1;
          meta_waddr = line_i;
          meta_wdata = {1'b1, 1'b0, tag_i};
        end
      end
      sawc_pkg::ST_ACCESS: begin
        // acnt 0,1: read words aw, aw+1; on a write, acnt 2: write low word; 3: write high word if touched
        cd_raddr = CDB'(32'(line_i) * WPL + 32'(aw) + 32'(acnt[0]));
        if (r_func && acnt == (WOB+1)'(2)) begin
          cd_we = 1'b1;
          cd_waddr = CDB'(32'(line_i) * WPL + 32'(aw));
          cd_wdata = r_wdata << (8 * ab);
          cd_be = bmask[7:0];
        end
        if (r_func && acnt == (WOB+1)'(3) && bmask[15:8] != 8'h00) begin
          cd_we = 1'b1;
          cd_waddr = CDB'(32'(line_i) * WPL + 32'(aw) + 1);
          cd_wdata = r_wdata >> (64 - 8 * ab);
          cd_be = bmask[15:8];
        end
        // a write leaves the line dirty
        if (r_func && acnt == (WOB+1)'(3)) begin
          meta_we = 1'b1;
          meta_waddr = line_i;
          meta_wdata = {1'b1, 1'b1, tag_i};
        end
      end
      default: ;
    endcase
    if (clearing) begin
      bm_we = 1'b1;
      bm_waddr = MB'(clr);
      bm_wdata = '0;
      meta_we = 1'b1;
      meta_waddr = LB'(clr);
      meta_wdata = '0;
    end
  end

  assign pair = {cd_rdata, lo_word} >> (8 * ab);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sawc_pkg::ST_IDLE;
      lfsr <= sawc_pkg::LfsrSeed;
      hcnt <= '0;
      mcnt <= '0;
      clr <= '0;
      clearing <= 1'b1;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr <= clr + (CLRB+1)'(1);
        if (32'(clr) == CLR_N - 1) clearing <= 1'b0;
      end
      unique case (state)
        sawc_pkg::ST_IDLE: begin
          if (in_valid && !clearing) begin
            r_func <= func; r_addr <= addr; r_wdata <= wdata; r_size <= size;
            wscan <= '0; found <= 1'b0; inv_found <= 1'b0; way <= '0;
            wrb <= 1'b0; rdata <= '0; hit <= 1'b0; error <= 1'b0;
          end
        end
        sawc_pkg::ST_LOOKUP: begin
          // one way read per cycle, compared the cycle after
          wcnt <= '0;
          acnt <= '0;
          if (bad) begin
            error <= 1'b1;
          end else if (found) begin
            hit <= 1'b1;
            hcnt <= sawc_pkg::sat_inc(hcnt);
          end else if (32'(wscan) <= WAYS) begin
            if (wscan != '0) begin
              if (m_valid && m_tag == tag_i) begin
                found <= 1'b1;
                way <= prev_way;
              end else if (!m_valid && !inv_found) begin
                inv_found <= 1'b1;
                inv_way <= prev_way;
              end
              // keep what a full-set eviction would need
              if (prev_way == lfsr_pick) begin
                vic_dirty <= m_dirty;
                vic_tag <= m_tag;
              end
            end
            wscan <= wscan + (WB+1)'(1);
          end else begin
            mcnt <= sawc_pkg::sat_inc(mcnt);
            if (inv_found) begin
              way <= inv_way;
            end else begin
              lfsr <= sawc_pkg::lfsr_step(lfsr);
              way <= lfsr_pick;
            end
          end
        end
        sawc_pkg::ST_WBACK: begin
          wrb <= 1'b1;
          wcnt <= (32'(wcnt) == WPL) ? '0 : wcnt + (WOB+1)'(1);
        end
        sawc_pkg::ST_FILL: begin
          wcnt <= wcnt + (WOB+1)'(1);
        end
        sawc_pkg::ST_ACCESS: begin
          acnt <= acnt + (WOB+1)'(1);
          if (acnt == (WOB+1)'(1)) lo_word <= cd_rdata;
          if (acnt == (WOB+1)'(2) && !r_func) begin
            rdata <= pair[63:0] & ((ssz == 4'd8) ? 64'hFFFF_FFFF_FFFF_FFFF :
                                   ((64'h1 << (8 * ssz)) - 64'h1));
          end
        end
        default: ;
      endcase
    end
  end

  assign wrote_back = wrb;
  assign hit_count = hcnt;
  assign miss_count = mcnt;
endmodule
